@@ rtl/vfb_pkg.sv @@
// ----------------------------------------------------------------------------
// vfb_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// velocity frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package vfb_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] SyncA   = 8'hAA;
  localparam logic [7:0] SyncB   = 8'h55;
  localparam logic [7:0] CmdCode = 8'h60;
  localparam logic [7:0] EndMark = 8'hDD;

  // Byte position within the outgoing frame, in transmit order.
  typedef enum logic [3:0] {
    PosSyncA  = 4'd0,
    PosSyncB  = 4'd1,
    PosCmd    = 4'd2,
    PosLinHi  = 4'd3,
    PosLinLo  = 4'd4,
    PosAngHi  = 4'd5,
    PosAngLo  = 4'd6,
    PosCrcHi  = 4'd7,
    PosCrcLo  = 4'd8,
    PosEnd    = 4'd9
  } vfb_pos_e;

  // One command on its way to the serializer, with the running CRC.
  typedef struct packed {
    logic [15:0] lin;
    logic [15:0] ang;
    logic [15:0] crc;
  } vfb_frame_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] data);
    logic [15:0] c;
    c = acc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // The three header bytes never change, so their CRC is a constant.
  localparam logic [15:0] CrcHeader =
    crc_byte(crc_byte(crc_byte(CrcInit, SyncA), SyncB), CmdCode);

endpackage

`default_nettype wire

@@ rtl/vfb_if.sv @@
// ----------------------------------------------------------------------------
// vfb_cmd_if / vfb_frame_if
// Valid/ready channels for velocity commands and for outgoing frame bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfb_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] linear_speed;
  logic signed [15:0] angular_speed;

  modport source (output valid, output linear_speed, output angular_speed, input ready);
  modport sink   (input valid, input linear_speed, input angular_speed, output ready);
endinterface

interface vfb_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

`default_nettype wire

@@ rtl/vfb_crc_pipe.sv @@
// ----------------------------------------------------------------------------
// vfb_crc_pipe
// Four-stage CRC pipeline: each stage folds one payload byte into the CRC
// that starts from the precomputed header value.
// ----------------------------------------------------------------------------
`default_nettype none

module vfb_crc_pipe (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [15:0]        in_lin_i,
  input  wire logic [15:0]        in_ang_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      vfb_pkg::vfb_frame_t out_item_o
);
  import vfb_pkg::*;

  localparam int unsigned Stages = 4;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] rdy;
  vfb_frame_t        item_q [Stages];
  vfb_frame_t        item_d [Stages];

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    rdy[Stages-1] = !vld_q[Stages-1] || out_ready_i;
    for (int i = Stages - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  always_comb begin
    item_d[0].lin = in_lin_i;
    item_d[0].ang = in_ang_i;
    item_d[0].crc = crc_byte(CrcHeader, in_lin_i[15:8]);
    item_d[1]     = item_q[0];
    item_d[1].crc = crc_byte(item_q[0].crc, item_q[0].lin[7:0]);
    item_d[2]     = item_q[1];
    item_d[2].crc = crc_byte(item_q[1].crc, item_q[1].ang[15:8]);
    item_d[3]     = item_q[2];
    item_d[3].crc = crc_byte(item_q[2].crc, item_q[2].ang[7:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int i = 1; i < Stages; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      item_q[0] <= item_d[0];
    end
    for (int i = 1; i < Stages; i++) begin
      if (rdy[i] && vld_q[i-1]) begin
        item_q[i] <= item_d[i];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Stages-1];
  assign out_item_o  = item_q[Stages-1];

endmodule

`default_nettype wire

@@ rtl/velocity_frame_builder_crc16_core.sv @@
// ----------------------------------------------------------------------------
// velocity_frame_builder_crc16_core
// Turns each velocity command into a ten-byte framed serial command with a
// CRC-16/MODBUS check field, one byte per output request.
// ----------------------------------------------------------------------------
// Each accepted command leaves as ten bytes: AA 55 60, linear hi/lo,
// angular hi/lo, CRC hi/lo and DD, with frame_last set on DD. The CRC runs
// through a four-stage pipeline, one payload byte per stage, and the frame
// register then puts out one byte per cycle while the output is ready. A new
// command loads as the last byte of the previous frame is taken. The first
// byte is valid once a command has passed the pipeline and frame register.
// Up to four commands wait in the pipeline while a frame is going out, so
// input requests keep being taken until the pipeline is full.
`default_nettype none

module velocity_frame_builder_crc16_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  vfb_cmd_if.sink    cmd_i,
  vfb_frame_if.source frame_o
);
  import vfb_pkg::*;

  logic       pipe_vld;
  logic       pipe_rdy;
  vfb_frame_t pipe_item;

  vfb_frame_t frame_q;
  logic       busy_q;
  vfb_pos_e   pos_q;
  vfb_pos_e   pos_d;
  logic       byte_take;
  logic       frame_done;

  vfb_crc_pipe u_crc_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .in_lin_i    (cmd_i.linear_speed),
    .in_ang_i    (cmd_i.angular_speed),
    .out_valid_o (pipe_vld),
    .out_ready_i (pipe_rdy),
    .out_item_o  (pipe_item)
  );

  assign byte_take  = busy_q && frame_o.ready;
  assign frame_done = byte_take && (pos_q == PosEnd);
  assign pipe_rdy   = !busy_q || frame_done;

  always_comb begin
    pos_d = vfb_pos_e'(pos_q + 4'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= PosSyncA;
    end else if (pipe_rdy && pipe_vld) begin
      busy_q <= 1'b1;
      pos_q  <= PosSyncA;
    end else if (frame_done) begin
      busy_q <= 1'b0;
      pos_q  <= PosSyncA;
    end else if (byte_take) begin
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_rdy && pipe_vld) begin
      frame_q <= pipe_item;
    end
  end

  always_comb begin
    case (pos_q)
      PosSyncA: frame_o.frame_byte = SyncA;
      PosSyncB: frame_o.frame_byte = SyncB;
      PosCmd:   frame_o.frame_byte = CmdCode;
      PosLinHi: frame_o.frame_byte = frame_q.lin[15:8];
      PosLinLo: frame_o.frame_byte = frame_q.lin[7:0];
      PosAngHi: frame_o.frame_byte = frame_q.ang[15:8];
      PosAngLo: frame_o.frame_byte = frame_q.ang[7:0];
      PosCrcHi: frame_o.frame_byte = frame_q.crc[15:8];
      PosCrcLo: frame_o.frame_byte = frame_q.crc[7:0];
      PosEnd:   frame_o.frame_byte = EndMark;
      default:  frame_o.frame_byte = 8'h00;
    endcase
  end

  assign frame_o.valid      = busy_q;
  assign frame_o.frame_last = (pos_q == PosEnd);

`ifndef SYNTH
  // A new frame may only load when the previous one has fully gone out.
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_vld && pipe_rdy |-> !busy_q || (frame_o.ready && frame_o.frame_last))
    else $error("frame register reloaded while a frame was in progress");

  // Every frame starts with the first sync byte.
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(pipe_vld && pipe_rdy) |-> busy_q && pos_q == PosSyncA)
    else $error("frame did not start at the first sync byte");

  // The byte position only advances when a byte has been taken.
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !frame_o.ready |=> $stable(pos_q) && busy_q)
    else $error("frame position moved without an output request");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the velocity frame builder. Velocity commands go in
// through a valid/ready driver with random idle bursts. A monitor with random
// stalls checks every outgoing frame byte and its last-byte flag against
// frames predicted in the bench. Each prediction carries its own CRC-16/MODBUS.
// ----------------------------------------------------------------------------
module tb;
  import vfb_pkg::*;

  typedef struct packed {
    logic [15:0] lin;
    logic [15:0] ang;
    logic        drain_first;  // hold this request until all frames are out
  } speed_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  localparam int RandomCmds = 380;
  localparam int TailCmds   = 40;

  logic clk = 1'b0;
  logic rst_n;

  vfb_cmd_if   cmd_bus ();
  vfb_frame_if frame_bus ();

  velocity_frame_builder_crc16_core DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cmd_i   (cmd_bus),
    .frame_o (frame_bus)
  );

  speed_cmd_t  cmds_pending[$];
  frame_byte_t frame_bytes_due[$];
  int          error_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflected CRC-16 over one byte, shifting the data in bit by bit.
  function automatic logic [15:0] modbus_crc_byte(logic [15:0] acc, logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = {1'b0, c[15:1]};
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  function automatic void queue_frame(logic [15:0] lin, logic [15:0] ang);
    logic [7:0]  body[7];
    logic [15:0] crc;
    body = '{SyncA, SyncB, CmdCode, lin[15:8], lin[7:0], ang[15:8], ang[7:0]};
    crc  = CrcInit;
    for (int k = 0; k < 7; k++) begin
      crc = modbus_crc_byte(crc, body[k]);
      frame_bytes_due.push_back('{data: body[k], last: 1'b0});
    end
    frame_bytes_due.push_back('{data: crc[15:8], last: 1'b0});
    frame_bytes_due.push_back('{data: crc[7:0], last: 1'b0});
    frame_bytes_due.push_back('{data: EndMark, last: 1'b1});
  endfunction

  // The closing stretch of the run goes without idling on either side.
  function automatic bit in_tail();
    return cmds_pending.size() < TailCmds;
  endfunction

  function automatic logic [15:0] pick_speed();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0:       v = 16'($urandom_range(0, 64)) - 16'd32;
      1: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      2:       v = 16'h0001 << $urandom_range(0, 15);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic add_cmd(logic [15:0] lin, logic [15:0] ang, logic drain);
    cmds_pending.push_back('{lin: lin, ang: ang, drain_first: drain});
  endtask

  always @(posedge clk or negedge rst_n) begin : cmd_driver
    logic       fire;
    logic       next_valid;
    if (!rst_n) begin
      cmd_bus.valid         <= 1'b0;
      cmd_bus.linear_speed  <= '0;
      cmd_bus.angular_speed <= '0;
      send_gap = 0;
    end else begin
      fire = cmd_bus.valid && cmd_bus.ready;
      if (fire) begin
        queue_frame(cmd_bus.linear_speed, cmd_bus.angular_speed);
        void'(cmds_pending.pop_front());
      end
      // A request that is still waiting keeps its payload untouched.
      if (!cmd_bus.valid || fire) begin
        next_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmds_pending.size() > 0 && !in_tail() && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 12) - 1;
        end else if (cmds_pending.size() > 0 &&
                     (!cmds_pending[0].drain_first || frame_bytes_due.size() == 0)) begin
          next_valid = 1'b1;
        end
        cmd_bus.valid <= next_valid;
        if (next_valid) begin
          cmd_bus.linear_speed  <= cmds_pending[0].lin;
          cmd_bus.angular_speed <= cmds_pending[0].ang;
        end else begin
          cmd_bus.linear_speed  <= 16'($urandom);
          cmd_bus.angular_speed <= 16'($urandom);
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : frame_monitor
    frame_byte_t want;
    logic        next_ready;
    if (!rst_n) begin
      frame_bus.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (frame_bus.valid && frame_bus.ready) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected frame byte, expected none, actual byte %h last %b",
                   $time, frame_bus.frame_byte, frame_bus.frame_last);
          error_count++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (frame_bus.frame_byte !== want.data || frame_bus.frame_last !== want.last) begin
            $display("%0t: frame byte mismatch, expected byte %h last %b, actual byte %h last %b",
                     $time, want.data, want.last, frame_bus.frame_byte, frame_bus.frame_last);
            error_count++;
          end
        end
      end
      next_ready = 1'b0;
      if (recv_gap > 0) begin
        recv_gap--;
      end else if (!in_tail() && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(1, 12) - 1;
      end else begin
        next_ready = 1'b1;
      end
      frame_bus.ready <= next_ready;
    end
  end

  initial begin : stimulus
    cmd_bus.valid         = 1'b0;
    cmd_bus.linear_speed  = '0;
    cmd_bus.angular_speed = '0;
    frame_bus.ready       = 1'b0;
    rst_n                 = 1'b0;

    add_cmd(16'h0000, 16'h0000, 1'b0);
    add_cmd(16'h7FFF, 16'h8000, 1'b0);
    add_cmd(16'h8000, 16'h7FFF, 1'b0);
    add_cmd(16'hFFFF, 16'hFFFF, 1'b0);
    add_cmd(16'h5555, 16'hAAAA, 1'b0);
    add_cmd(16'hAAAA, 16'h5555, 1'b0);
    add_cmd(16'h0001, 16'hFFFF, 1'b0);
    add_cmd(16'h00FF, 16'hFF00, 1'b0);
    add_cmd(16'hFF00, 16'h00FF, 1'b0);
    add_cmd(16'h8000, 16'h0000, 1'b0);
    add_cmd(16'h0000, 16'h8000, 1'b0);
    add_cmd(16'h0001, 16'h0001, 1'b0);
    add_cmd(16'h7FFF, 16'h7FFF, 1'b0);
    add_cmd(16'h8000, 16'h8000, 1'b0);
    add_cmd(16'hAAAA, 16'hDD55, 1'b0);
    add_cmd(16'h0060, 16'hAA55, 1'b0);

    // The first random command waits until the directed frames have drained.
    for (int n = 0; n < RandomCmds; n++) begin
      add_cmd(pick_speed(), pick_speed(), n == 0 || $urandom_range(0, 59) == 0);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (cmds_pending.size() > 0) @(posedge clk);
    while (frame_bytes_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
